@@ rtl/core/gelp_pkg.sv @@
// Shared types, constants and helper functions of the Gaussian emission log-probability unit.
`timescale 1ns / 1ps
package gelp_pkg;

	localparam int MAX_STATES = 64;
	localparam int SLOT_W = 6;
	localparam int CNT_W = 7;
	localparam int TAB_W = 94;
	localparam int PROB_W = 32;

	localparam logic [CNT_W-1:0] STATE_COUNT_RESET = 7'd8;
	localparam logic [CNT_W-1:0] MAX_COUNT = 7'(MAX_STATES);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic REG_STATE_COUNT = 1'b0;

	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
	localparam logic [32:0] INV_LN2_Q32 = 33'h171547653;
	localparam logic [31:0] NEG_LN_2PI_Q16 = 32'hFFFE_2981;
	localparam logic [32:0] EXP_LIMIT = 33'(24 << 16);
	localparam logic [26:0] OFF_HALF_VAR = 27'(40 << 20);
	localparam logic [26:0] OFF_LSE = 27'(30 << 20);
	localparam logic [30:0] ONE_Q30 = 31'(1 << 30);
	localparam logic [5:0] DIV_LAST = 6'd47;
	localparam logic [5:0] SQ_LAST = 6'd19;
	localparam logic [5:0] EXP_LAST = 6'd16;
	localparam logic [5:0] NORM_TOP = 6'd47;

	typedef logic [30:0] pow_tab_t [0:16];

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD,
		S_DT,
		S_DIV_LD,
		S_DIV,
		S_DIV_ACC,
		S_DR,
		S_VMUL,
		S_LG_LD,
		S_LG_NORM,
		S_LG_SQ,
		S_LG_CHK,
		S_LN_MUL,
		S_LN_FIN,
		S_SCORE,
		S_EXP_RD,
		S_EXP_X,
		S_EXP_Y,
		S_EXP_STEP,
		S_EXP_MULD,
		S_EXP_ACC,
		S_EMIT_RD,
		S_EMIT_OUT
	} gelp_state_t;

	typedef enum logic [1:0] {
		LG_HALF_VAR,
		LG_LSE,
		LG_MISS
	} lg_mode_t;

	// Integer square root, evaluated only while elaborating the constant table.
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] bit_v;
		x = x_in;
		r = '0;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + bit_v) begin
				x = x - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r;
	endfunction

	// Entry 0 is 1.0 and entry b > 0 is 2^(-2^-b) in Q30; from entry 2 on, each is the square root of the one before.
	function automatic pow_tab_t build_pow_tab();
		pow_tab_t t;
		logic [63:0] v;
		t[0] = ONE_Q30;
		v = isqrt64(64'd1 << 59);
		t[1] = v[30:0];
		for (int i = 2; i <= 16; i++) begin
			v = isqrt64({3'b0, t[i-1], 30'b0});
			t[i] = v[30:0];
		end
		return t;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

	function automatic logic [31:0] sat32(input logic signed [47:0] x);
		if (x > 48'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (x < -48'sd2147483648) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

endpackage

@@ rtl/core/gelp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module gelp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/gaussian_emission_log_prob_unit.sv @@
// Top level of the Gaussian emission log-probability unit: sequencer, shared multiplier, divider.
`timescale 1ns / 1ps
// A load request writes the table entry directly and never raises busy. A sample request with N
// states first scores each state (two divider runs, the log2 normalize and 20 squarings on the
// shared multiplier per state), then forms the exponent sum over the N scores and the final log2,
// and last emits the N results, one strobe per state. A missing intensity skips scoring: the
// unit takes log2(N), then emits the N results.
// The receiver cannot stall. Asynchronous reset sets state_count to 8 and idles the sequencer.
module gaussian_emission_log_prob_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [gelp_pkg::SLOT_W-1:0]   state_slot,
	input  logic signed [23:0]            theta_mean,
	input  logic signed [23:0]            rho_mean,
	input  logic [22:0]                   theta_variance,
	input  logic [22:0]                   rho_variance,
	input  logic signed [23:0]            theta_value,
	input  logic signed [23:0]            rho_value,
	output logic                          valid,
	output logic [gelp_pkg::SLOT_W-1:0]   out_state,
	output logic signed [31:0]            log_prob,
	output logic                          last_state,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	import gelp_pkg::*;

	gelp_state_t state_q, state_d;
	lg_mode_t mode_q;

	logic [CNT_W-1:0] sc_q, n_q, active_n;
	logic [SLOT_W-1:0] idx_q;
	logic miss_q, div_second_q, neg_q;
	logic [23:0] th_q, rh_q, mr_q;
	logic [22:0] vt_q, vr_q;
	logic [64:0] prod_q, prod_d;
	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [47:0] num_q;
	logic [27:0] rem_q;
	logic [5:0] step_q;
	logic [46:0] acc_q;
	logic [47:0] lg_x_q, lg_x_ld;
	logic [5:0] p_q;
	logic [31:0] m_q;
	logic [19:0] frac_q;
	logic [31:0] ln_q, max_q, l_q;
	logic [15:0] f_q;
	logic [5:0] k_q;
	logic [30:0] e_q;
	logic [36:0] sum_q;
	logic valid_q, last_q;
	logic [SLOT_W-1:0] out_state_q;
	logic [31:0] log_prob_q;

	logic tab_we, prob_we, cfg_wr, last_idx;
	logic [TAB_W-1:0] tab_rdata;
	logic [PROB_W-1:0] prob_rdata;
	logic [23:0] rd_mt, rd_mr;
	logic [22:0] rd_vt, rd_vr;
	logic [24:0] dt_full, dt_neg, dr_full, dr_neg;
	logic [23:0] dt_abs, dr_abs;
	logic [27:0] den;
	logic [28:0] rem_sh;
	logic div_ge;
	logic [25:0] lg_val;
	logic [26:0] lg_off, lg_v, lg_v_neg;
	logic [25:0] v_abs;
	logic [65:0] rnd37, rnd36;
	logic [31:0] ln_mag, ln_new, score, lse_val, emit_s, emit_val;
	logic [32:0] sq;
	logic [32:0] exp_x;
	logic exp_big;
	logic [36:0] term;

	assign pready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_STATE_COUNT) ? {25'b0, sc_q} : 32'b0;

	assign valid = valid_q;
	assign out_state = out_state_q;
	assign log_prob = log_prob_q;
	assign last_state = last_q;

	always_comb begin
		if (sc_q == '0) begin
			active_n = 7'd1;
		end else if (sc_q > MAX_COUNT) begin
			active_n = MAX_COUNT;
		end else begin
			active_n = sc_q;
		end
	end

	gelp_ram #(.WIDTH(TAB_W), .DEPTH(MAX_STATES)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (state_slot),
		.wdata ({theta_mean, rho_mean, theta_variance, rho_variance}),
		.raddr (idx_q),
		.rdata (tab_rdata)
	);

	gelp_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES)) u_prob (
		.clk   (clk),
		.we    (prob_we),
		.waddr (idx_q),
		.wdata (score),
		.raddr (idx_q),
		.rdata (prob_rdata)
	);

	assign rd_mt = tab_rdata[93:70];
	assign rd_mr = tab_rdata[69:46];
	assign rd_vt = tab_rdata[45:23];
	assign rd_vr = tab_rdata[22:0];

	assign last_idx = ({1'b0, idx_q} == (n_q - 7'd1));

	// Distances from the state means, as magnitudes for the squaring.
	assign dt_full = {th_q[23], th_q} - {rd_mt[23], rd_mt};
	assign dt_neg = -dt_full;
	assign dt_abs = dt_full[24] ? dt_neg[23:0] : dt_full[23:0];
	assign dr_full = {rh_q[23], rh_q} - {mr_q[23], mr_q};
	assign dr_neg = -dr_full;
	assign dr_abs = dr_full[24] ? dr_neg[23:0] : dr_full[23:0];

	// One restoring division step per cycle, quotient shifted into num_q.
	assign den = {(div_second_q ? vr_q : vt_q), 5'b0};
	assign rem_sh = {rem_q, num_q[47]};
	assign div_ge = (rem_sh >= {1'b0, den});

	assign lg_val = {p_q, frac_q};
	always_comb begin
		unique case (mode_q)
			LG_HALF_VAR: lg_off = OFF_HALF_VAR;
			LG_LSE:      lg_off = OFF_LSE;
			default:     lg_off = '0;
		endcase
	end
	assign lg_v = {1'b0, lg_val} - lg_off;
	assign lg_v_neg = -lg_v;
	assign v_abs = lg_v[26] ? lg_v_neg[25:0] : lg_v[25:0];

	// Natural log scaling with rounding toward minus infinity.
	assign rnd37 = {1'b0, prod_q} + {29'b0, {37{1'b1}}};
	assign rnd36 = {1'b0, prod_q} + {30'b0, {36{1'b1}}};
	always_comb begin
		if (mode_q == LG_HALF_VAR) begin
			ln_mag = neg_q ? 32'(rnd37[65:37]) : 32'(prod_q[64:37]);
		end else begin
			ln_mag = neg_q ? 32'(rnd36[65:36]) : 32'(prod_q[64:36]);
		end
	end
	assign ln_new = neg_q ? -ln_mag : ln_mag;

	assign score = sat32({acc_q[46], acc_q} - {{16{ln_q[31]}}, ln_q});
	assign lse_val = sat32({{16{max_q[31]}}, max_q} + {{16{ln_new[31]}}, ln_new});
	assign emit_s = miss_q ? 32'b0 : prob_rdata;
	assign emit_val = sat32({{16{emit_s[31]}}, emit_s} - {{16{l_q[31]}}, l_q});

	assign sq = prod_q[63:31];
	assign exp_x = {max_q[31], max_q} - {prob_rdata[31], prob_rdata};
	assign exp_big = (exp_x >= EXP_LIMIT);
	assign term = {6'b0, e_q} >> k_q;

	always_comb begin
		unique case (mode_q)
			LG_HALF_VAR: lg_x_ld = {2'b0, prod_q[45:0]};
			LG_LSE:      lg_x_ld = {11'b0, sum_q};
			default:     lg_x_ld = {41'b0, n_q};
		endcase
	end

	assign prod_d = {33'b0, mul_a} * {32'b0, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sc_q <= STATE_COUNT_RESET;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && (paddr[2] == REG_STATE_COUNT)) begin
				sc_q <= pwdata[CNT_W-1:0];
			end
			valid_q <= (state_q == S_EMIT_OUT);
		end
	end

	// Sequencer: next state, memory writes and shared multiplier operands.
	always_comb begin
		state_d = state_q;
		tab_we = 1'b0;
		prob_we = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && (opcode == OP_LOAD)) begin
					tab_we = 1'b1;
				end else if (start) begin
					state_d = (theta_value[23] || rho_value[23]) ? S_LG_LD : S_RD;
				end
			end
			S_RD: state_d = S_DT;
			S_DT: begin
				mul_a = {8'b0, dt_abs};
				mul_b = {9'b0, dt_abs};
				state_d = S_DIV_LD;
			end
			S_DIV_LD: state_d = S_DIV;
			S_DIV: begin
				if (step_q == DIV_LAST) begin
					state_d = S_DIV_ACC;
				end
			end
			S_DIV_ACC: state_d = div_second_q ? S_VMUL : S_DR;
			S_DR: begin
				mul_a = {8'b0, dr_abs};
				mul_b = {9'b0, dr_abs};
				state_d = S_DIV_LD;
			end
			S_VMUL: begin
				mul_a = {9'b0, vt_q};
				mul_b = {10'b0, vr_q};
				state_d = S_LG_LD;
			end
			S_LG_LD: state_d = S_LG_NORM;
			S_LG_NORM: begin
				if (lg_x_q[47]) begin
					state_d = S_LG_SQ;
				end
			end
			S_LG_SQ: begin
				mul_a = m_q;
				mul_b = {1'b0, m_q};
				state_d = S_LG_CHK;
			end
			S_LG_CHK: state_d = (step_q == SQ_LAST) ? S_LN_MUL : S_LG_SQ;
			S_LN_MUL: begin
				mul_a = {6'b0, v_abs};
				mul_b = {1'b0, LN2_Q32};
				state_d = S_LN_FIN;
			end
			S_LN_FIN: state_d = (mode_q == LG_HALF_VAR) ? S_SCORE : S_EMIT_RD;
			S_SCORE: begin
				prob_we = 1'b1;
				state_d = last_idx ? S_EXP_RD : S_RD;
			end
			S_EXP_RD: state_d = S_EXP_X;
			S_EXP_X: begin
				mul_a = {11'b0, exp_x[20:0]};
				mul_b = INV_LN2_Q32;
				state_d = exp_big ? S_EXP_ACC : S_EXP_Y;
			end
			S_EXP_Y: state_d = S_EXP_STEP;
			S_EXP_STEP: begin
				mul_a = {1'b0, e_q};
				mul_b = {2'b0, POW_TAB[step_q[4:0]]};
				if (f_q[15]) begin
					state_d = S_EXP_MULD;
				end else if (step_q == EXP_LAST) begin
					state_d = S_EXP_ACC;
				end
			end
			S_EXP_MULD: state_d = (step_q == EXP_LAST) ? S_EXP_ACC : S_EXP_STEP;
			S_EXP_ACC: state_d = last_idx ? S_LG_LD : S_EXP_RD;
			S_EMIT_RD: state_d = S_EMIT_OUT;
			S_EMIT_OUT: state_d = last_idx ? S_IDLE : S_EMIT_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LG_HALF_VAR;
			idx_q <= '0;
			n_q <= STATE_COUNT_RESET;
			miss_q <= 1'b0;
			div_second_q <= 1'b0;
			step_q <= '0;
			p_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && (opcode == OP_SAMPLE)) begin
						n_q <= active_n;
						idx_q <= '0;
						miss_q <= theta_value[23] || rho_value[23];
						mode_q <= LG_MISS;
					end
				end
				S_DT: div_second_q <= 1'b0;
				S_DIV_LD: step_q <= '0;
				S_DIV: step_q <= step_q + 6'd1;
				S_DR: div_second_q <= 1'b1;
				S_VMUL: mode_q <= LG_HALF_VAR;
				S_LG_LD: p_q <= NORM_TOP;
				S_LG_NORM: begin
					if (lg_x_q[47]) begin
						step_q <= '0;
					end else begin
						p_q <= p_q - 6'd1;
					end
				end
				S_LG_CHK: step_q <= step_q + 6'd1;
				S_LN_FIN: begin
					if (mode_q != LG_HALF_VAR) begin
						idx_q <= '0;
					end
				end
				S_SCORE: idx_q <= last_idx ? '0 : idx_q + 6'd1;
				S_EXP_Y: step_q <= 6'd1;
				S_EXP_STEP: begin
					if (!f_q[15]) begin
						step_q <= step_q + 6'd1;
					end
				end
				S_EXP_MULD: step_q <= step_q + 6'd1;
				S_EXP_ACC: begin
					if (last_idx) begin
						mode_q <= LG_LSE;
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				S_EMIT_OUT: begin
					if (!last_idx) begin
						idx_q <= idx_q + 6'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers, some of which (lg_x_q, f_q) steer the sequencer; they take no reset.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		unique case (state_q)
			S_IDLE: begin
				th_q <= theta_value;
				rh_q <= rho_value;
			end
			S_DT: begin
				vt_q <= (rd_vt == '0) ? 23'd1 : rd_vt;
				vr_q <= (rd_vr == '0) ? 23'd1 : rd_vr;
				mr_q <= rd_mr;
				acc_q <= {{15{NEG_LN_2PI_Q16[31]}}, NEG_LN_2PI_Q16};
			end
			S_DIV_LD: begin
				num_q <= prod_q[47:0];
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? 28'(rem_sh - {1'b0, den}) : rem_sh[27:0];
				num_q <= {num_q[46:0], div_ge};
			end
			S_DIV_ACC: acc_q <= acc_q - num_q[46:0];
			S_LG_LD: lg_x_q <= (lg_x_ld == '0) ? 48'd1 : lg_x_ld;
			S_LG_NORM: begin
				if (lg_x_q[47]) begin
					m_q <= lg_x_q[47:16];
				end else begin
					lg_x_q <= {lg_x_q[46:0], 1'b0};
				end
			end
			S_LG_CHK: begin
				m_q <= sq[32] ? sq[32:1] : sq[31:0];
				frac_q <= {frac_q[18:0], sq[32]};
			end
			S_LN_MUL: neg_q <= lg_v[26];
			S_LN_FIN: begin
				ln_q <= ln_new;
				if (mode_q == LG_LSE) begin
					l_q <= lse_val;
				end else if (mode_q == LG_MISS) begin
					l_q <= ln_new;
				end
			end
			S_SCORE: begin
				if ((idx_q == '0) || ($signed(score) > $signed(max_q))) begin
					max_q <= score;
				end
				if (last_idx) begin
					sum_q <= '0;
				end
			end
			S_EXP_X: begin
				if (exp_big) begin
					e_q <= '0;
					k_q <= '0;
				end
			end
			S_EXP_Y: begin
				k_q <= prod_q[53:48];
				f_q <= prod_q[47:32];
				e_q <= ONE_Q30;
			end
			S_EXP_STEP: f_q <= {f_q[14:0], 1'b0};
			S_EXP_MULD: e_q <= prod_q[60:30];
			S_EXP_ACC: sum_q <= sum_q + term;
			S_EMIT_OUT: begin
				out_state_q <= idx_q;
				log_prob_q <= emit_val;
				last_q <= last_idx;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the Gaussian emission log-probability unit.
`timescale 1ns / 1ps
module tb_top;
	import gelp_pkg::*;

	localparam longint LIMIT_CYCLES = 40000000;
	localparam longint LN2_K = 64'd2977044472;
	localparam longint unsigned INV_LN2_K = 64'd6196328019;
	localparam longint NEG_LN_2PI_K = -120447;

	typedef struct {
		logic [5:0] state_idx;
		logic signed [31:0] prob;
		logic last;
	} emission_t;

	logic clk, arst_n, start, busy, opcode, valid, last_state;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic [5:0] state_slot, out_state;
	logic signed [23:0] theta_mean, rho_mean, theta_value, rho_value;
	logic [22:0] theta_variance, rho_variance;
	logic signed [31:0] log_prob;

	emission_t pending_scores[$];
	longint mean_th[64], mean_rh[64], var_th[64], var_rh[64];
	longint unsigned exp_steps[17];
	logic [6:0] count_reg;
	int idle_pct;
	int errors;
	longint cycles;

	gaussian_emission_log_prob_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x_in);
		longint unsigned x, r, b;
		x = x_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Base-2 log with 20 fraction bits, by repeated squaring of the mantissa.
	function automatic longint log2_q20(longint unsigned x_in);
		longint unsigned x, m, frac;
		int p;
		x = (x_in == 0) ? 1 : x_in;
		p = 0;
		frac = 0;
		while (p < 63 && (x >> (p + 1)) != 0) p++;
		m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
		for (int i = 1; i <= 20; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac = frac | (64'd1 << (20 - i));
			end
		end
		return (longint'(p) << 20) + longint'(frac);
	endfunction

	function automatic longint unsigned exp_neg_q30(longint x_in);
		longint unsigned y, k, f, e;
		longint x;
		x = x_in;
		e = 64'd1 << 30;
		if (x >= (64'sd24 << 16)) return 0;
		if (x < 0) x = 0;
		y = (longint'(x) * INV_LN2_K) >> 32;
		k = y >> 16;
		f = y & 64'hFFFF;
		for (int b = 1; b <= 16; b++)
			if (f[16 - b]) e = (e * exp_steps[b]) >> 30;
		return e >> k;
	endfunction

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic int states_in_use();
		if (count_reg == 0) return 1;
		if (count_reg > 64) return 64;
		return count_reg;
	endfunction

	// Scores every state in use for one sample and queues the normalized results.
	task automatic predict_sample(longint th, longint rh);
		longint score[64];
		longint lnn, peak, norm, dt, dr, hl;
		longint unsigned vt, vr, total;
		int n;
		emission_t e;
		n = states_in_use();
		total = 0;
		if (th < 0 || rh < 0) begin
			lnn = (log2_q20(n) * LN2_K) >>> 36;
			for (int i = 0; i < n; i++) score[i] = -lnn;
			norm = 0;
		end else begin
			for (int i = 0; i < n; i++) begin
				vt = (var_th[i] == 0) ? 1 : var_th[i];
				vr = (var_rh[i] == 0) ? 1 : var_rh[i];
				dt = th - mean_th[i];
				dr = rh - mean_rh[i];
				hl = ((log2_q20(vt * vr) - (64'sd40 << 20)) * LN2_K) >>> 37;
				score[i] = clip32(NEG_LN_2PI_K - hl - longint'((dt * dt) / (vt << 5))
					- longint'((dr * dr) / (vr << 5)));
			end
			peak = score[0];
			for (int i = 1; i < n; i++) if (score[i] > peak) peak = score[i];
			for (int i = 0; i < n; i++) total += exp_neg_q30(peak - score[i]);
			norm = clip32(peak + (((log2_q20(total) - (64'sd30 << 20)) * LN2_K) >>> 36));
		end
		for (int i = 0; i < n; i++) begin
			e.state_idx = i[5:0];
			e.prob = 32'(clip32(score[i] - norm));
			e.last = (i == n - 1);
			pending_scores.push_back(e);
		end
	endtask

	// Drives one request, after a random idle gap, and holds it until the unit is no longer busy.
	task automatic send_request(logic op, logic [5:0] slot, logic [23:0] mt, logic [23:0] mr,
		logic [22:0] vt, logic [22:0] vr, logic [23:0] tv, logic [23:0] rv);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		state_slot <= slot;
		theta_mean <= mt;
		rho_mean <= mr;
		theta_variance <= vt;
		rho_variance <= vr;
		theta_value <= tv;
		rho_value <= rv;
		do @(posedge clk); while (busy);
		if (op == OP_LOAD) begin
			mean_th[slot] = longint'($signed(mt));
			mean_rh[slot] = longint'($signed(mr));
			var_th[slot] = vt;
			var_rh[slot] = vr;
		end else begin
			predict_sample(longint'($signed(tv)), longint'($signed(rv)));
		end
	endtask

	task automatic load_state(logic [5:0] slot, logic [23:0] mt, logic [23:0] mr,
		logic [22:0] vt, logic [22:0] vr);
		send_request(OP_LOAD, slot, mt, mr, vt, vr, 24'($urandom), 24'($urandom));
	endtask

	task automatic score_sample(logic [23:0] tv, logic [23:0] rv);
		send_request(OP_SAMPLE, 6'($urandom), 24'($urandom), 24'($urandom),
			23'($urandom), 23'($urandom), tv, rv);
	endtask

	// Lets the unit finish all work, so that the count register may be changed.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_scores.size() != 0 || busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_count(logic [31:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * REG_STATE_COUNT);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		count_reg = value[6:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [22:0] rand_variance();
		case ($urandom_range(3))
			0: return 23'($urandom_range(1, 8388607));
			1: return 23'(1 << $urandom_range(0, 22)) | 23'($urandom_range(0, 255));
			default: return 23'($urandom_range(1 << 14, 1 << 21));
		endcase
	endfunction

	function automatic logic [23:0] near_value(longint center);
		longint v;
		v = center + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
		if (v < 0) v = 0;
		if (v > 8388607) v = 8388607;
		return 24'(v);
	endfunction

	task automatic test_directed();
		// Every slot is loaded before any sample reads the table.
		for (int i = 0; i < 64; i++)
			load_state(i[5:0], 24'($urandom_range(0, 1 << 22)), 24'($urandom_range(0, 1 << 22)),
				rand_variance(), rand_variance());
		load_state(6'd0, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'd1);
		load_state(6'd1, 24'd0, 24'd0, 23'd1, 23'h7FFFFF);
		load_state(6'd2, 24'h100000, 24'h100000, 23'd0, 23'd0);
		load_state(6'd63, 24'h800000, 24'h7FFFFF, 23'h100000, 23'h100000);
		score_sample(24'd0, 24'd0);
		score_sample(24'h7FFFFF, 24'h7FFFFF);
		score_sample(24'h100000, 24'h100000);
		score_sample(24'h800000, 24'h100000);
		score_sample(24'h100000, 24'hFFFFFF);
		score_sample(24'h7FFFFF, 24'd0);
		drain();
		// Consecutive samples with no gap between them.
		score_sample(24'h080000, 24'h200000);
		score_sample(24'h800000, 24'h800000);
	endtask

	task automatic test_count_extremes();
		write_count(32'd0);
		score_sample(24'h100000, 24'h100000);
		score_sample(24'hC00000, 24'h000001);
		write_count(32'd1);
		score_sample(24'h200000, 24'h050000);
		write_count(32'hFFFF_FF7F);
		score_sample(24'h7FFFFF, 24'd0);
		score_sample(24'd5, 24'h800005);
		write_count(32'd64);
		score_sample(24'h123456, 24'h654321);
		write_count(32'd2);
		score_sample(24'h300000, 24'h010000);
		score_sample(24'h000001, 24'hF00000);
	endtask

	task automatic test_random(int pct, int items, int count_max);
		int r;
		logic [5:0] slot;
		idle_pct = pct;
		for (int chunk = 0; chunk < 3; chunk++) begin
			write_count(32'($urandom_range(2, count_max)) | ($urandom & 32'hFFFF_FF80));
			for (int k = 0; k < items / 3; k++) begin
				r = $urandom_range(99);
				slot = 6'($urandom_range(0, states_in_use() - 1));
				if (r < 25)
					load_state(($urandom_range(3) == 0) ? 6'($urandom) : slot,
						24'($urandom_range(0, 8388607)), 24'($urandom_range(0, 8388607)),
						rand_variance(), rand_variance());
				else if (r < 35)
					score_sample(24'($urandom) | 24'h800000, 24'($urandom));
				else if (r < 50)
					score_sample(24'($urandom), 24'($urandom));
				else
					score_sample(near_value(mean_th[slot]), near_value(mean_rh[slot]));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (pending_scores.size() == 0) begin
				$error("result for state %0d with nothing expected", out_state);
				errors++;
			end else begin
				emission_t e;
				e = pending_scores.pop_front();
				if (out_state !== e.state_idx) begin
					$error("out_state expected %0d got %0d", e.state_idx, out_state);
					errors++;
				end
				if (log_prob !== e.prob) begin
					$error("log_prob expected %0d got %0d", e.prob, log_prob);
					errors++;
				end
				if (last_state !== e.last) begin
					$error("last_state expected %0b got %0b", e.last, last_state);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		count_reg = STATE_COUNT_RESET;
		exp_steps[0] = 64'd1 << 30;
		exp_steps[1] = int_sqrt(64'd1 << 59);
		for (int i = 2; i <= 16; i++) exp_steps[i] = int_sqrt(exp_steps[i - 1] << 30);
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_LOAD;
		state_slot = '0;
		theta_mean = '0;
		rho_mean = '0;
		theta_variance = '0;
		rho_variance = '0;
		theta_value = '0;
		rho_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_count_extremes();
		test_random(0, 111, 7);
		test_random(79, 111, 7);
		test_random(20, 111, 6);
		test_random(0, 30, 16);
		drain();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/gelp_pkg.sv
rtl/core/gelp_ram.sv
rtl/core/gaussian_emission_log_prob_unit.sv
dv/tb_top.sv
